[hdl/srb_pkg.sv]
// Shared types, sizes and helpers for the subflow reorder buffer.
// Used by every module in hdl/.
`default_nettype none
package srb_pkg;
   localparam int NUM_SLOTS   = 2;
   localparam int QUEUE_DEPTH = 8;
   localparam int TAG_WIDTH   = 16;

   localparam int TAG_W     = (TAG_WIDTH < 16) ? TAG_WIDTH : 16;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int HEAD_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_SLOTS * QUEUE_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   typedef struct packed {
      logic [31:0] path_id;
      logic [31:0] seq_num;
      logic [15:0] packet_tag;
   } req_type;

   typedef struct packed {
      logic [15:0] out_tag;
      logic [31:0] out_seq;
      logic        from_buffer;
      logic        last;
   } rsp_type;

   // Classified request handed from front to back.
   typedef struct packed {
      logic              slot_ok;   // a slot was found or claimed
      logic              fresh;     // slot claimed by this request
      logic [SLOT_W-1:0] slot;
      logic [31:0]       seq;
      logic [TAG_W-1:0]  tag;
   } cmd_type;

   typedef struct packed {
      logic [31:0]      seq;
      logic [TAG_W-1:0] tag;
   } ent_type;

   typedef struct packed {
      logic idle;
      logic pend_v;
   } bstat_type;

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [HEAD_W-1:0] h);
      return ADDR_W'(int'(s) * QUEUE_DEPTH + int'(h));
   endfunction

   function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
      return (h == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
   endfunction

   function automatic logic [HEAD_W-1:0] tail_of(input logic [HEAD_W-1:0] h,
                                                 input logic [FILL_W-1:0] f);
      int t;
      t = int'(h) + int'(f);
      if (t >= QUEUE_DEPTH) t = t - QUEUE_DEPTH;
      return HEAD_W'(t);
   endfunction
endpackage
`default_nettype wire

[hdl/srb_front.sv]
// Front end: subflow lookup and slot claim, emits classified requests.
// Depends on srb_pkg.
`default_nettype none
module srb_front import srb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         cmd_valid,
   input  wire logic    cmd_ready,
   output cmd_type      cmd_data
);
   logic        in_use_ff [NUM_SLOTS];
   logic        in_use_in [NUM_SLOTS];
   logic [31:0] owner_ff  [NUM_SLOTS];
   logic        hit, free;
   logic [SLOT_W-1:0] hit_idx, free_idx;

   always_comb begin
      hit = 1'b0; free = 1'b0; hit_idx = '0; free_idx = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!hit && in_use_ff[i] && owner_ff[i] == req_data.path_id) begin
            hit = 1'b1; hit_idx = SLOT_W'(i);
         end
         if (!free && !in_use_ff[i]) begin
            free = 1'b1; free_idx = SLOT_W'(i);
         end
      end
   end

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;

   always_comb begin
      cmd_data.slot_ok = hit | free;
      cmd_data.fresh   = !hit & free;
      cmd_data.slot    = hit ? hit_idx : free_idx;
      cmd_data.seq     = req_data.seq_num;
      cmd_data.tag     = req_data.packet_tag[TAG_W-1:0];
      for (int i = 0; i < NUM_SLOTS; i++) in_use_in[i] = in_use_ff[i];
      if (req_valid && cmd_ready && !hit && free) in_use_in[free_idx] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) in_use_ff[i] <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_SLOTS; i++) in_use_ff[i] <= in_use_in[i];
      end
      if (req_valid && cmd_ready && !hit && free) owner_ff[free_idx] <= req_data.path_id;
   end
endmodule
`default_nettype wire

[hdl/srb_cmd_fifo.sv]
// Two-entry queue of classified requests between front and back.
// Depends on srb_pkg.
`default_nettype none
module srb_cmd_fifo import srb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_valid,
   output logic         wr_ready,
   input  wire cmd_type wr_data,
   output logic         rd_valid,
   input  wire logic    rd_ready,
   output cmd_type      rd_data
);
   cmd_type    ent_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = ent_ff[rp_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) ent_ff[wp_ff] <= wr_data;
   end
endmodule
`default_nettype wire

[hdl/srb_back.sv]
// Back end: per-slot queues, delivery counter, drain and scan sequencer,
// result staging and output register. Depends on srb_pkg.
`default_nettype none
module srb_back import srb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_ready,
   input  wire cmd_type cmd_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   output bstat_type    stat
);
   localparam logic [2:0] S_IDLE = 3'd0, S_FIN = 3'd1, S_DRW = 3'd2,
                          S_PASS = 3'd3, S_SCW = 3'd4;

   logic [2:0]        state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [HEAD_W-1:0] head_ff [NUM_SLOTS];
   logic [HEAD_W-1:0] head_in [NUM_SLOTS];
   logic [FILL_W-1:0] fill_ff [NUM_SLOTS];
   logic [FILL_W-1:0] fill_in [NUM_SLOTS];
   logic [31:0]       ntd_ff, ntd_in;
   logic              pend_v_ff, pend_v_in, out_v_ff, out_v_in;
   rsp_type           pend_ff, pend_in, out_ff, out_in;

   ent_type           mem [MEM_DEPTH];
   ent_type           rd_ff, wd;
   logic              we, re;
   logic [ADDR_W-1:0] wa, ra;

   logic              out_free, go, gen_v, hit;
   rsp_type           gen;
   logic [HEAD_W-1:0] h_cur, h_nx;
   logic [FILL_W-1:0] f_cur;

   assign rsp_valid   = out_v_ff;
   assign rsp_data    = out_ff;
   assign cmd_ready   = (state_ff == S_IDLE);
   assign stat.idle   = (state_ff == S_IDLE);
   assign stat.pend_v = pend_v_ff;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; idx_in = idx_ff; ntd_in = ntd_ff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         head_in[i] = head_ff[i]; fill_in[i] = fill_ff[i];
      end
      pend_v_in = pend_v_ff; pend_in = pend_ff;
      out_free  = !out_v_ff || rsp_ready;
      out_v_in  = out_v_ff && !rsp_ready;
      out_in    = out_ff;
      we = 1'b0; re = 1'b0; wa = '0; ra = '0; wd = '0;
      gen_v = 1'b0; gen = '0; hit = 1'b0;
      h_cur = '0; h_nx = '0; f_cur = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_data;
               h_cur  = cmd_data.fresh ? '0 : head_ff[cmd_data.slot];
               f_cur  = cmd_data.fresh ? '0 : fill_ff[cmd_data.slot];
               if (cmd_data.fresh) begin
                  head_in[cmd_data.slot] = '0; fill_in[cmd_data.slot] = '0;
               end
               gen = '{out_tag: 16'(cmd_data.tag), out_seq: cmd_data.seq,
                       from_buffer: 1'b0, last: 1'b0};
               if (!cmd_data.slot_ok) begin
                  gen_v = 1'b1; state_in = S_FIN;
               end else if (f_cur == FILL_W'(QUEUE_DEPTH)) begin
                  re = 1'b1; ra = mem_addr(cmd_data.slot, h_cur); state_in = S_DRW;
               end else if (cmd_data.seq == ntd_ff) begin
                  gen_v = 1'b1; ntd_in = ntd_ff + 32'd1; idx_in = '0;
                  re = 1'b1; ra = mem_addr('0, head_ff[0]); state_in = S_SCW;
               end else if (cmd_data.seq > ntd_ff) begin
                  we = 1'b1; wa = mem_addr(cmd_data.slot, tail_of(h_cur, f_cur));
                  wd = '{seq: cmd_data.seq, tag: cmd_data.tag};
                  fill_in[cmd_data.slot] = f_cur + 1'b1;
               end else begin
                  gen_v = 1'b1; state_in = S_FIN;
               end
            end
         end
         S_DRW: begin
            gen_v = 1'b1;
            gen   = '{out_tag: 16'(rd_ff.tag), out_seq: rd_ff.seq,
                      from_buffer: 1'b1, last: 1'b0};
            h_nx  = head_inc(head_ff[cmd_ff.slot]);
            if (!pend_v_ff || out_free) begin
               head_in[cmd_ff.slot] = h_nx;
               fill_in[cmd_ff.slot] = fill_ff[cmd_ff.slot] - 1'b1;
               if (fill_ff[cmd_ff.slot] == FILL_W'(1)) state_in = S_PASS;
               else begin
                  re = 1'b1; ra = mem_addr(cmd_ff.slot, h_nx);
               end
            end
         end
         S_PASS: begin
            gen_v = 1'b1;
            gen   = '{out_tag: 16'(cmd_ff.tag), out_seq: cmd_ff.seq,
                      from_buffer: 1'b0, last: 1'b0};
            if (!pend_v_ff || out_free) state_in = S_FIN;
         end
         S_SCW: begin
            hit = (fill_ff[idx_ff] != '0) && (rd_ff.seq == ntd_ff);
            gen = '{out_tag: 16'(rd_ff.tag), out_seq: rd_ff.seq,
                    from_buffer: 1'b1, last: 1'b0};
            if (hit) begin
               gen_v = 1'b1;
               if (!pend_v_ff || out_free) begin
                  h_nx = head_inc(head_ff[idx_ff]);
                  head_in[idx_ff] = h_nx;
                  fill_in[idx_ff] = fill_ff[idx_ff] - 1'b1;
                  ntd_in = ntd_ff + 32'd1;
                  idx_in = '0;
                  re = 1'b1; ra = mem_addr('0, head_in[0]);
               end
            end else if (idx_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               state_in = S_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
               re = 1'b1; ra = mem_addr(idx_in, head_ff[idx_in]);
            end
         end
         S_FIN: begin
            // final staged result leaves flagged as last
            if (out_free) begin
               out_v_in = 1'b1; out_in = pend_ff; out_in.last = 1'b1;
               pend_v_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      go = !(gen_v && pend_v_ff && !out_free);
      if (gen_v && go) begin
         if (pend_v_ff) begin
            out_v_in = 1'b1; out_in = pend_ff;
         end
         pend_v_in = 1'b1; pend_in = gen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ntd_ff <= '0; idx_ff <= '0;
         pend_v_ff <= 1'b0; out_v_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            head_ff[i] <= '0; fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in; ntd_ff <= ntd_in; idx_ff <= idx_in;
         pend_v_ff <= pend_v_in; out_v_ff <= out_v_in;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            head_ff[i] <= head_in[i]; fill_ff[i] <= fill_in[i];
         end
      end
      cmd_ff  <= cmd_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (re) rd_ff <= mem[ra];
   end
endmodule
`default_nettype wire

[hdl/subflow_reorder_buffer.sv]
// Top level of the subflow reorder buffer: front, request queue, back.
// Depends on srb_pkg, srb_front, srb_cmd_fifo, srb_back.
//
// Packets enter on req_ with a subflow id, global sequence number and tag,
// and leave on rsp_ largely in sequence order; a request yields zero or more
// results, the final one flagged with last. The front looks the subflow up in
// a small slot table (claiming a free slot on first sight) and hands the
// classified request through a two-deep queue to the back, which owns the
// per-slot FIFO memory and the next-to-deliver counter. A full queue is
// handled in steps: accept, drain each buffered entry, pass the arriving
// packet, final handoff. After an in-order packet the back scans slot heads
// one slot per cycle through the single registered memory read port,
// holding on a hit while the output stages are full and restarting from
// slot 0 after every hit. A result waits in the output register while the
// front keeps accepting further requests as long as the two-deep queue has
// room. No clearing pass after reset: queue entries are tracked by head and
// fill counts.
`default_nettype none
module subflow_reorder_buffer import srb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   logic      f_valid, f_ready, b_valid, b_ready;
   cmd_type   f_data, b_data;
   bstat_type bstat;

   srb_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
   );

   srb_cmd_fifo u_fifo (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
   );

   srb_back u_back (
      .clock, .reset,
      .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_data(b_data),
      .rsp_valid, .rsp_ready, .rsp_data, .stat(bstat)
   );

   // back is never idle with a result still staged
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      bstat.idle |-> !bstat.pend_v) else $error("staged result while idle");

   // an accepted request is in the queue on the next cycle
   a_req_queued: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> b_valid) else $error("request lost");

   // a queued request not taken by the back stays queued
   a_queue_holds: assert property (@(posedge clock) disable iff (reset)
      b_valid && !b_ready |=> b_valid) else $error("queue dropped request");
endmodule
`default_nettype wire

[dv/tb_subflow_reorder_buffer.sv]
// Self-checking testbench for the subflow reorder buffer: drives packets,
// predicts deliveries with a behavioral copy of the reorder logic, checks rsp_.
// Depends on srb_pkg and subflow_reorder_buffer.
`default_nettype none
module tb_subflow_reorder_buffer;
   import srb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   subflow_reorder_buffer dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: mirrors the delivery counter and per-subflow queues.
   logic [31:0]    next_seq;
   logic           slot_used [NUM_SLOTS];
   logic [31:0]    slot_sid [NUM_SLOTS];
   logic [31:0]    q_seq [NUM_SLOTS][QUEUE_DEPTH];
   logic [15:0]    q_tag [NUM_SLOTS][QUEUE_DEPTH];
   int             q_head [NUM_SLOTS];
   int             q_fill [NUM_SLOTS];

   req_type        pending_reqs [$];
   rsp_type        expected_deliveries [$];
   rsp_type        burst [$];

   int  errors = 0;
   int  n_sent = 0;
   int  n_seen = 0;
   int  n_buffered = 0;
   int  cycles = 0;
   int  hold_off = 0;
   bit  stimulus_done = 0;

   function automatic rsp_type mk(input logic [15:0] tag, input logic [31:0] seq,
                                  input logic fb);
      rsp_type r;
      r.out_tag = tag;
      r.out_seq = seq;
      r.from_buffer = fb;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic drain_head(input int s);
      burst.push_back(mk(q_tag[s][q_head[s]], q_seq[s][q_head[s]], 1'b1));
      q_head[s] = (q_head[s] + 1) % QUEUE_DEPTH;
      q_fill[s]--;
   endtask

   // Works out the deliveries caused by one accepted request.
   task automatic predict_deliveries(input req_type p);
      int  s;
      bit  found;
      int  pos;
      s = -1;
      burst.delete();
      for (int i = 0; i < NUM_SLOTS; i++)
         if (s < 0 && slot_used[i] && slot_sid[i] == p.path_id) s = i;
      if (s < 0) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (s < 0 && !slot_used[i]) begin
               s = i;
               slot_used[i] = 1'b1;
               slot_sid[i] = p.path_id;
               q_head[i] = 0;
               q_fill[i] = 0;
            end
         end
      end
      if (s < 0 || q_fill[s] >= QUEUE_DEPTH) begin
         // no slot, or queue full: flush the queue, then pass the packet
         if (s >= 0) while (q_fill[s] > 0) drain_head(s);
         burst.push_back(mk(p.packet_tag, p.seq_num, 1'b0));
      end else if (p.seq_num == next_seq) begin
         burst.push_back(mk(p.packet_tag, p.seq_num, 1'b0));
         next_seq++;
         found = 1;
         while (found) begin
            found = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!found && slot_used[i] && q_fill[i] > 0 &&
                   q_seq[i][q_head[i]] == next_seq) begin
                  drain_head(i);
                  next_seq++;
                  found = 1;
               end
            end
         end
      end else if (p.seq_num > next_seq) begin
         pos = (q_head[s] + q_fill[s]) % QUEUE_DEPTH;
         q_seq[s][pos] = p.seq_num;
         q_tag[s][pos] = p.packet_tag;
         q_fill[s]++;
         n_buffered++;
      end else begin
         burst.push_back(mk(p.packet_tag, p.seq_num, 1'b0));
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[k]) expected_deliveries.push_back(burst[k]);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Sample handshake signals at the rising edge.
   logic req_ready_s;
   always @(posedge clock) req_ready_s <= req_ready;

   // Driver: changes inputs on the falling edge, one request per handshake.
   int  tx_gap = 0;
   bit  tx_accepted;
   always @(negedge clock) begin
      if (!reset) begin
         tx_accepted = req_valid && req_ready_s;
         if (tx_accepted) begin
            predict_deliveries(req_data);
            n_sent++;
         end
         if (!req_valid || tx_accepted) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               tx_gap = gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result against the oldest expectation.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         n_seen <= n_seen + 1;
         if (expected_deliveries.size() == 0) begin
            $error("unexpected result tag=%h seq=%h", rsp_data.out_tag, rsp_data.out_seq);
            errors++;
         end else begin
            rsp_type e;
            e = expected_deliveries.pop_front();
            if (e.out_tag !== rsp_data.out_tag) begin
               $error("out_tag exp %h got %h", e.out_tag, rsp_data.out_tag);
               errors++;
            end
            if (e.out_seq !== rsp_data.out_seq) begin
               $error("out_seq exp %h got %h", e.out_seq, rsp_data.out_seq);
               errors++;
            end
            if (e.from_buffer !== rsp_data.from_buffer) begin
               $error("from_buffer exp %b got %b", e.from_buffer, rsp_data.from_buffer);
               errors++;
            end
            if (e.last !== rsp_data.last) begin
               $error("last exp %b got %b", e.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // Receiver stall pattern, with one long hold-off counted here.
   int rx_gap = 0;
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rx_gap <= gap_len();
      end
   end

   function automatic req_type pkt(input logic [31:0] sid, input logic [31:0] seq,
                                   input logic [15:0] tag);
      req_type p;
      p.path_id = sid;
      p.seq_num = seq;
      p.packet_tag = tag;
      return p;
   endfunction

   initial begin
      logic [31:0] sids [3];
      logic [31:0] base;
      int          n;
      next_seq = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_used[i] = 1'b0;
         q_head[i] = 0;
         q_fill[i] = 0;
      end
      // Directed: in order, buffered then drained, late, table full, queue full.
      pending_reqs.push_back(pkt(32'h0, 32'd0, 16'h0000));
      pending_reqs.push_back(pkt(32'hFFFF_FFFF, 32'd2, 16'hFFFF));
      pending_reqs.push_back(pkt(32'h0, 32'd3, 16'h1234));
      pending_reqs.push_back(pkt(32'h0, 32'd1, 16'hABCD));
      pending_reqs.push_back(pkt(32'h0, 32'd0, 16'h5555));
      pending_reqs.push_back(pkt(32'h7, 32'hFFFF_FFFF, 16'hAAAA));
      for (int i = 0; i < QUEUE_DEPTH + 1; i++)
         pending_reqs.push_back(pkt(32'h0, 32'd100 + i, 16'(i)));
      pending_reqs.push_back(pkt(32'hFFFF_FFFF, 32'd4, 16'h0F0F));
      pending_reqs.push_back(pkt(32'h0, 32'd5, 16'hF0F0));
      // Random: small reordered sequence windows, mostly over known subflows.
      base = 32'd6;
      sids[0] = 32'h0;
      sids[1] = 32'hFFFF_FFFF;
      sids[2] = $urandom;
      n = 0;
      while (n < 85) begin
         int w;
         int perm [$];
         w = $urandom_range(1, 6);
         for (int k = 0; k < w; k++) perm.push_back(k);
         perm.shuffle();
         foreach (perm[k]) begin
            if ($urandom_range(0, 9) == 0)
               pending_reqs.push_back(pkt($urandom, $urandom, 16'($urandom)));
            else
               pending_reqs.push_back(pkt(sids[$urandom_range(0, 2)],
                                          base + perm[k], 16'($urandom)));
            n++;
         end
         base += w;
         if ($urandom_range(0, 7) == 0) base += $urandom_range(1, 3);
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // Long receiver stall while the sender keeps offering requests.
      repeat (150) @(posedge clock);
      hold_off = 400;
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_deliveries.size() == 0);
      repeat (200) @(posedge clock);
      stimulus_done = 1;
   end

   always @(posedge clock) begin
      if (stimulus_done) begin
         $display("covered %0d requests, %0d results, %0d packets buffered",
                  n_sent, n_seen, n_buffered);
         if (errors == 0 && expected_deliveries.size() == 0)
            $display("subflow_reorder_buffer regression: pass");
         else
            $display("subflow_reorder_buffer regression: fail");
         $finish;
      end else if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("subflow_reorder_buffer regression: fail");
         $finish;
      end
   end
endmodule
`default_nettype wire

[filelist.f]
hdl/srb_pkg.sv
hdl/srb_front.sv
hdl/srb_cmd_fifo.sv
hdl/srb_back.sv
hdl/subflow_reorder_buffer.sv
dv/tb_subflow_reorder_buffer.sv
